// File: rtl/assert_macros.svh
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/slx_pkg.sv
`default_nettype none

package slx_pkg;

    typedef logic [2:0] t_kind;
    typedef logic [3:0] t_cat;

    localparam t_kind KIND_SKIP    = 3'd0;
    localparam t_kind KIND_START   = 3'd1;
    localparam t_kind KIND_CONT    = 3'd2;
    localparam t_kind KIND_STRING  = 3'd3;
    localparam t_kind KIND_INVALID = 3'd4;

    localparam t_cat CAT_VARIABLE = 4'd0;
    localparam t_cat CAT_WORD     = 4'd1;
    localparam t_cat CAT_NUMBER   = 4'd2;
    localparam t_cat CAT_PLUS     = 4'd3;
    localparam t_cat CAT_MINUS    = 4'd4;
    localparam t_cat CAT_OPERATOR = 4'd5;
    localparam t_cat CAT_BRACKET  = 4'd6;
    localparam t_cat CAT_QUOTE    = 4'd7;
    localparam t_cat CAT_COMMA    = 4'd8;
    localparam t_cat CAT_QUESTION = 4'd9;
    localparam t_cat CAT_COLON    = 4'd10;
    localparam t_cat CAT_INVALID  = 4'd15;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_QUEST  = 8'h3F;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UF     = 8'h46;
    localparam logic [7:0] CH_US     = 8'h53;
    localparam logic [7:0] CH_UX     = 8'h58;
    localparam logic [7:0] CH_UZ     = 8'h5A;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LF_    = 8'h66;
    localparam logic [7:0] CH_LN     = 8'h6E;
    localparam logic [7:0] CH_LR     = 8'h72;
    localparam logic [7:0] CH_LS     = 8'h73;
    localparam logic [7:0] CH_LT_    = 8'h74;
    localparam logic [7:0] CH_LX     = 8'h78;
    localparam logic [7:0] CH_LZ     = 8'h7A;
    localparam logic [7:0] CH_PIPE   = 8'h7C;
    localparam logic [7:0] CH_TILDE  = 8'h7E;

    typedef struct packed {
        logic [7:0] out_char;
        t_kind      kind;
        t_cat       category;
        logic       end_of_text;
    } t_result;

endpackage

`default_nettype wire

// File: rtl/script_lexer_core.sv
// Each accepted result is registered in the output register, or in the skid register.
// Throughput: one character per cycle; the lexer state updates in the same cycle.
// A skid register holds one result while the output side stalls; the input stalls only
// while that register is full.
// Reset is synchronous and active low; it clears the lexer state and both result valid flags.
`default_nettype none

module script_lexer_core
    import slx_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_ch,
    input  wire logic       i_last,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [7:0]      o_out_char,
    output logic [2:0]      o_kind,
    output logic [3:0]      o_category,
    output logic            o_end_of_text
);

    function automatic logic f_digit(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    function automatic logic f_alpha(input logic [7:0] c);
        return ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_UA) && (c <= CH_UZ));
    endfunction

    function automatic logic f_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic f_op(input logic [7:0] c);
        return (c == CH_STAR) || (c == CH_SLASH) || (c == CH_PCT) || (c == CH_EQ) ||
               (c == CH_GT) || (c == CH_LT) || (c == CH_BANG) || (c == CH_PIPE) ||
               (c == CH_AMP) || (c == CH_CARET) || (c == CH_TILDE);
    endfunction

    function automatic t_cat f_classify(input logic [7:0] c);
        t_cat k;
        if (c == CH_DOLLAR) k = CAT_VARIABLE;
        else if (f_alpha(c)) k = CAT_WORD;
        else if (f_digit(c)) k = CAT_NUMBER;
        else if (c == CH_PLUS) k = CAT_PLUS;
        else if (c == CH_MINUS) k = CAT_MINUS;
        else if (f_op(c)) k = CAT_OPERATOR;
        else if ((c == CH_LPAREN) || (c == CH_RPAREN) || (c == CH_LBRACK) ||
                 (c == CH_RBRACK)) k = CAT_BRACKET;
        else if (c == CH_COMMA) k = CAT_COMMA;
        else if ((c == CH_DQUOTE) || (c == CH_SQUOTE)) k = CAT_QUOTE;
        else if (c == CH_QUEST) k = CAT_QUESTION;
        else if (c == CH_COLON) k = CAT_COLON;
        else k = CAT_INVALID;
        return k;
    endfunction

    function automatic logic f_continues(input logic [7:0] c, input t_cat cat,
                                         input logic first_lt, input logic first_gt);
        logic r;
        case (cat)
            CAT_VARIABLE, CAT_WORD: r = f_alpha(c) || f_digit(c) || (c == CH_UNDER);
            CAT_NUMBER: r = f_digit(c) || ((c >= CH_UA) && (c <= CH_UF)) ||
                            ((c >= CH_LA) && (c <= CH_LF_)) || (c == CH_LX) ||
                            (c == CH_UX) || (c == CH_LS) || (c == CH_US) || (c == CH_DOT);
            CAT_PLUS: r = (c == CH_PLUS) || (c == CH_EQ);
            CAT_MINUS: r = (c == CH_MINUS) || (c == CH_EQ);
            CAT_OPERATOR: r = (c == CH_EQ) || ((c == CH_LT) && first_lt) ||
                              ((c == CH_GT) && first_gt);
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    logic    r_open_valid, n_open_valid;
    t_cat    r_open_cat, n_open_cat;
    logic    r_first_lt, n_first_lt;
    logic    r_first_gt, n_first_gt;
    logic    r_in_string, n_in_string;
    logic    r_escape, n_escape;
    logic    r_out_valid;
    t_result r_out;
    logic    r_skid_valid;
    t_result r_skid;
    t_result n_res;
    t_cat    w_class;
    logic    w_in_acc;
    logic    w_out_free;

    assign w_in_acc   = i_in_valid && !r_skid_valid;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_class    = f_classify(i_ch);

    always_comb begin
        n_open_valid = r_open_valid;
        n_open_cat   = r_open_cat;
        n_first_lt   = r_first_lt;
        n_first_gt   = r_first_gt;
        n_in_string  = r_in_string;
        n_escape     = r_escape;
        n_res.out_char    = i_ch;
        n_res.kind        = KIND_SKIP;
        n_res.category    = CAT_VARIABLE;
        n_res.end_of_text = i_last || (i_ch == CH_NUL);

        if (i_ch == CH_NUL) begin
            n_open_valid = 1'b0;
            n_open_cat   = CAT_VARIABLE;
            n_first_lt   = 1'b0;
            n_first_gt   = 1'b0;
            n_in_string  = 1'b0;
            n_escape     = 1'b0;
        end else if (r_in_string) begin
            n_res.category = CAT_QUOTE;
            if (r_escape) begin
                n_escape   = 1'b0;
                n_res.kind = KIND_STRING;
                if (i_ch == CH_LN) n_res.out_char = CH_LF;
                else if (i_ch == CH_LR) n_res.out_char = CH_CR;
                else if (i_ch == CH_LT_) n_res.out_char = CH_TAB;
            end else if (i_ch == CH_BSLASH) begin
                n_escape   = 1'b1;
                n_res.kind = KIND_SKIP;
            end else if ((i_ch == CH_DQUOTE) || (i_ch == CH_SQUOTE)) begin
                n_in_string = 1'b0;
                n_res.kind  = KIND_CONT;
            end else begin
                n_res.kind = KIND_STRING;
            end
        end else if (r_open_valid && f_continues(i_ch, r_open_cat, r_first_lt, r_first_gt)) begin
            n_res.kind     = KIND_CONT;
            n_res.category = r_open_cat;
            if (r_open_cat >= CAT_PLUS) begin
                n_open_valid = 1'b0;
                n_open_cat   = CAT_VARIABLE;
                n_first_lt   = 1'b0;
                n_first_gt   = 1'b0;
            end
        end else begin
            n_open_valid = 1'b0;
            n_open_cat   = CAT_VARIABLE;
            n_first_lt   = 1'b0;
            n_first_gt   = 1'b0;
            if (f_space(i_ch)) begin
                n_res.kind = KIND_SKIP;
            end else if (w_class == CAT_INVALID) begin
                n_res.kind = KIND_INVALID;
            end else begin
                n_res.kind     = KIND_START;
                n_res.category = w_class;
                if (w_class == CAT_QUOTE) begin
                    n_in_string = 1'b1;
                    n_escape    = 1'b0;
                end else if (w_class <= CAT_OPERATOR) begin
                    n_open_valid = 1'b1;
                    n_open_cat   = w_class;
                    n_first_lt   = (i_ch == CH_LT);
                    n_first_gt   = (i_ch == CH_GT);
                end
            end
        end

        if (i_last) begin
            n_open_valid = 1'b0;
            n_open_cat   = CAT_VARIABLE;
            n_first_lt   = 1'b0;
            n_first_gt   = 1'b0;
            n_in_string  = 1'b0;
            n_escape     = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open_valid <= 1'b0;
            r_open_cat   <= CAT_VARIABLE;
            r_first_lt   <= 1'b0;
            r_first_gt   <= 1'b0;
            r_in_string  <= 1'b0;
            r_escape     <= 1'b0;
        end else if (w_in_acc) begin
            r_open_valid <= n_open_valid;
            r_open_cat   <= n_open_cat;
            r_first_lt   <= n_first_lt;
            r_first_gt   <= n_first_gt;
            r_in_string  <= n_in_string;
            r_escape     <= n_escape;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= w_in_acc;
            end
        end else if (w_in_acc) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (w_in_acc) begin
                r_out <= n_res;
            end
        end else if (w_in_acc) begin
            r_skid <= n_res;
        end
    end

    assign o_in_stall    = r_skid_valid;
    assign o_out_valid   = r_out_valid;
    assign o_out_char    = r_out.out_char;
    assign o_kind        = r_out.kind;
    assign o_category    = r_out.category;
    assign o_end_of_text = r_out.end_of_text;

endmodule

`default_nettype wire

// File: rtl/slx_checker.sv
`default_nettype none
`include "assert_macros.svh"

module slx_checker
    import slx_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire logic [7:0] o_out_char,
    input wire logic [2:0] o_kind,
    input wire logic [3:0] o_category,
    input wire logic       o_end_of_text
);

    logic [15:0] w_result;
    logic        w_held;
    logic        w_invalid;
    logic        w_string;
    logic        w_nul;
    logic        w_nul_label;

    assign w_result    = {o_out_char, o_kind, o_category, o_end_of_text};
    assign w_held      = o_out_valid && i_out_stall;
    assign w_invalid   = o_out_valid && (o_kind == KIND_INVALID);
    assign w_string    = o_out_valid && (o_kind == KIND_STRING);
    assign w_nul       = o_out_valid && (o_out_char == CH_NUL);
    assign w_nul_label = o_end_of_text && (o_kind == KIND_SKIP) && (o_category == CAT_VARIABLE);

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_held, o_out_valid && $stable(w_result))
    `ASSERT_IMPLY(a_invalid_cat, i_clk, i_rst_n, w_invalid, o_category == CAT_VARIABLE)
    `ASSERT_IMPLY(a_string_cat, i_clk, i_rst_n, w_string, o_category == CAT_QUOTE)
    `ASSERT_IMPLY(a_nul_end, i_clk, i_rst_n, w_nul, w_nul_label)

endmodule

bind script_lexer_core slx_checker u_slx_checker (.*);

`default_nettype wire

// File: tb/sv/tb_script_lexer_core.sv
`timescale 1ns / 1ps

module tb_script_lexer_core;
    import slx_pkg::*;

    localparam t_cat CAT_NONE = CAT_VARIABLE;

    localparam int PHASES = 4;
    localparam int SEND_IDLE_PCT [PHASES] = '{0, 70, 0, 34};
    localparam int RECV_STALL_PCT [PHASES] = '{0, 0, 70, 34};
    localparam int CHARS_PER_PHASE = 125;

    localparam logic [7:0] DIRECTED_TEXT [25] = '{
        CH_SPACE, CH_DOLLAR, CH_LA, CH_UNDER, CH_PLUS, CH_EQ, CH_LT, CH_LT,
        CH_0, CH_LX, CH_UF, CH_SQUOTE, CH_BSLASH, CH_LN, CH_BSLASH, CH_LZ,
        CH_DQUOTE, 8'hFF, CH_DQUOTE, CH_BSLASH, CH_NUL, CH_MINUS, CH_MINUS,
        CH_COMMA, 8'h80
    };
    localparam logic [7:0] OP_CHARS [11] = '{
        CH_STAR, CH_SLASH, CH_PCT, CH_EQ, CH_GT, CH_LT, CH_BANG, CH_PIPE,
        CH_AMP, CH_CARET, CH_TILDE
    };
    localparam logic [7:0] NUM_TAIL [8] = '{
        CH_LX, CH_UX, CH_LS, CH_US, CH_DOT, CH_LA, CH_UF, CH_9
    };
    localparam logic [7:0] SINGLE_CHARS [7] = '{
        CH_LPAREN, CH_RPAREN, CH_LBRACK, CH_RBRACK, CH_COMMA, CH_QUEST, CH_COLON
    };
    localparam logic [7:0] ESC_CHARS [4] = '{CH_LN, CH_LR, CH_LT_, CH_QUEST};

    class lex_scoreboard;
        t_result    expected_q[$];
        bit         tok_open;
        t_cat       tok_cat;
        logic [7:0] tok_first;
        bit         in_quote;
        bit         esc_armed;
        int         errors;
        int         checked;

        function new();
            clear_state();
            errors = 0;
            checked = 0;
        endfunction

        function void drop_token();
            tok_open = 1'b0;
            tok_cat = CAT_NONE;
            tok_first = CH_NUL;
        endfunction

        function void clear_state();
            drop_token();
            in_quote = 1'b0;
            esc_armed = 1'b0;
        endfunction

        function bit is_alpha(logic [7:0] c);
            return (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ);
        endfunction

        function bit is_digit(logic [7:0] c);
            return c >= CH_0 && c <= CH_9;
        endfunction

        function t_cat classify(logic [7:0] c);
            if (c == CH_DOLLAR) return CAT_VARIABLE;
            if (is_alpha(c)) return CAT_WORD;
            if (is_digit(c)) return CAT_NUMBER;
            case (c)
                CH_PLUS: return CAT_PLUS;
                CH_MINUS: return CAT_MINUS;
                CH_STAR, CH_SLASH, CH_PCT, CH_EQ, CH_GT, CH_LT, CH_BANG, CH_PIPE,
                CH_AMP, CH_CARET, CH_TILDE: return CAT_OPERATOR;
                CH_LPAREN, CH_RPAREN, CH_LBRACK, CH_RBRACK: return CAT_BRACKET;
                CH_COMMA: return CAT_COMMA;
                CH_DQUOTE, CH_SQUOTE: return CAT_QUOTE;
                CH_QUEST: return CAT_QUESTION;
                CH_COLON: return CAT_COLON;
                default: return CAT_INVALID;
            endcase
        endfunction

        function bit continues(logic [7:0] c);
            case (tok_cat)
                CAT_VARIABLE, CAT_WORD: return is_alpha(c) || is_digit(c) || c == CH_UNDER;
                CAT_NUMBER: return is_digit(c) || (c >= CH_UA && c <= CH_UF)
                    || (c >= CH_LA && c <= CH_LF_) || c == CH_LX || c == CH_UX
                    || c == CH_LS || c == CH_US || c == CH_DOT;
                CAT_PLUS: return c == CH_PLUS || c == CH_EQ;
                CAT_MINUS: return c == CH_MINUS || c == CH_EQ;
                CAT_OPERATOR: return c == CH_EQ || (c == CH_LT && tok_first == CH_LT)
                    || (c == CH_GT && tok_first == CH_GT);
                default: return 1'b0;
            endcase
        endfunction

        function void note_char(logic [7:0] c, logic last);
            t_result r;
            t_cat    k;
            r.out_char = c;
            r.kind = KIND_SKIP;
            r.category = CAT_NONE;
            r.end_of_text = last;
            if (c == CH_NUL) begin
                clear_state();
                r.end_of_text = 1'b1;
            end else if (in_quote) begin
                r.category = CAT_QUOTE;
                if (esc_armed) begin
                    esc_armed = 1'b0;
                    r.kind = KIND_STRING;
                    if (c == CH_LN) r.out_char = CH_LF;
                    else if (c == CH_LR) r.out_char = CH_CR;
                    else if (c == CH_LT_) r.out_char = CH_TAB;
                end else if (c == CH_BSLASH) begin
                    esc_armed = 1'b1;
                end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
                    in_quote = 1'b0;
                    r.kind = KIND_CONT;
                end else begin
                    r.kind = KIND_STRING;
                end
            end else if (tok_open && continues(c)) begin
                r.kind = KIND_CONT;
                r.category = tok_cat;
                if (tok_cat >= CAT_PLUS) drop_token();
            end else begin
                drop_token();
                k = classify(c);
                if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
                    r.kind = KIND_SKIP;
                end else if (k == CAT_INVALID) begin
                    r.kind = KIND_INVALID;
                end else begin
                    r.kind = KIND_START;
                    r.category = k;
                    if (k == CAT_QUOTE) begin
                        in_quote = 1'b1;
                        esc_armed = 1'b0;
                    end else if (k <= CAT_OPERATOR) begin
                        tok_open = 1'b1;
                        tok_cat = k;
                        tok_first = c;
                    end
                end
            end
            if (last) clear_state();
            expected_q.push_back(r);
        endfunction

        task report(string msg);
            errors++;
            $display("tb_script_lexer_core: mismatch %0d at %0t: %s", errors, $time, msg);
        endtask

        task check_result(t_result got);
            t_result want;
            if (expected_q.size() == 0) begin
                report($sformatf("label for char %02h with nothing pending", got.out_char));
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (got.out_char !== want.out_char)
                report($sformatf("out_char %02h, expected %02h", got.out_char, want.out_char));
            if (got.kind !== want.kind)
                report($sformatf("kind %0d, expected %0d (char %02h)",
                    got.kind, want.kind, want.out_char));
            if (got.category !== want.category)
                report($sformatf("category %0d, expected %0d (char %02h)",
                    got.category, want.category, want.out_char));
            if (got.end_of_text !== want.end_of_text)
                report($sformatf("end_of_text %0b, expected %0b (char %02h)",
                    got.end_of_text, want.end_of_text, want.out_char));
        endtask
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    logic [7:0] i_ch;
    logic       i_last;
    logic       o_out_valid;
    logic       i_out_stall;
    logic [7:0] o_out_char;
    logic [2:0] o_kind;
    logic [3:0] o_category;
    logic       o_end_of_text;

    lex_scoreboard sb;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int sent_count = 0;

    script_lexer_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_ch          (i_ch),
        .i_last        (i_last),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_char    (o_out_char),
        .o_kind        (o_kind),
        .o_category    (o_category),
        .o_end_of_text (o_end_of_text)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("tb_script_lexer_core: done, errors");
        $finish;
    end

    task automatic send_char(input logic [7:0] c, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_ch <= c;
        i_last <= last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_char(c, last);
        sent_count++;
    endtask

    // Builds one text from mostly well-formed tokens and sends it, ending it
    // with the last flag, a zero byte, or nothing at all.
    task automatic run_text();
        logic [7:0] text_q[$];
        logic [7:0] q;
        int ntok;
        int pick;
        int len;
        int ending;
        ntok = $urandom_range(2, 10);
        repeat (ntok) begin
            pick = $urandom_range(0, 19);
            len = $urandom_range(0, 4);
            if (pick < 3) begin
                text_q.push_back(pick == 0 ? CH_DOLLAR :
                    8'(($urandom_range(0, 1) ? CH_LA : CH_UA) + $urandom_range(0, 25)));
                repeat (len) begin
                    case ($urandom_range(0, 3))
                        0: q = 8'(CH_0 + $urandom_range(0, 9));
                        1: q = CH_UNDER;
                        2: q = 8'(CH_UA + $urandom_range(0, 25));
                        default: q = 8'(CH_LA + $urandom_range(0, 25));
                    endcase
                    text_q.push_back(q);
                end
            end else if (pick < 6) begin
                text_q.push_back(8'(CH_0 + $urandom_range(0, 9)));
                repeat (len) text_q.push_back(NUM_TAIL[$urandom_range(0, 7)]);
            end else if (pick < 10) begin
                if (pick < 8) q = $urandom_range(0, 1) ? CH_PLUS : CH_MINUS;
                else q = OP_CHARS[$urandom_range(0, 10)];
                text_q.push_back(q);
                case ($urandom_range(0, 2))
                    0: text_q.push_back(q);
                    1: text_q.push_back(CH_EQ);
                    default: ;
                endcase
            end else if (pick < 12) begin
                text_q.push_back(SINGLE_CHARS[$urandom_range(0, 6)]);
            end else if (pick < 15) begin
                text_q.push_back($urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE);
                repeat ($urandom_range(0, 6)) begin
                    if ($urandom_range(0, 3) == 0) begin
                        text_q.push_back(CH_BSLASH);
                        text_q.push_back($urandom_range(0, 1) ? ESC_CHARS[$urandom_range(0, 3)]
                            : 8'($urandom_range(1, 255)));
                    end else begin
                        text_q.push_back(8'($urandom_range(32, 126)));
                    end
                end
                text_q.push_back($urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE);
            end else if (pick < 18) begin
                text_q.push_back($urandom_range(0, 1) ? CH_SPACE
                    : 8'(CH_TAB + $urandom_range(0, 4)));
            end else begin
                text_q.push_back(8'($urandom_range(0, 255)));
            end
        end
        ending = $urandom_range(0, 3);
        if (ending == 0) text_q.push_back(CH_NUL);
        foreach (text_q[i])
            send_char(text_q[i], ending >= 2 && i == text_q.size() - 1);
    endtask

    initial begin
        t_result got;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                got.out_char = o_out_char;
                got.kind = o_kind;
                got.category = o_category;
                got.end_of_text = o_end_of_text;
                sb.check_result(got);
            end
            i_out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    initial begin
        int goal;
        sb = new();
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_ch <= CH_NUL;
        i_last <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED_TEXT[i])
            send_char(DIRECTED_TEXT[i], i == $size(DIRECTED_TEXT) - 1);

        for (int phase = 0; phase < PHASES; phase++) begin
            send_idle_pct = SEND_IDLE_PCT[phase];
            stall_pct = RECV_STALL_PCT[phase];
            goal = sent_count + CHARS_PER_PHASE;
            while (sent_count < goal) run_text();
        end
        i_in_valid <= 1'b0;

        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        $display("tb_script_lexer_core: %0d characters sent, %0d labels checked,",
            sent_count, sb.checked);
        $display("tb_script_lexer_core: over %0d input idle / output stall phases", PHASES);
        if (sb.errors == 0) begin
            $display("tb_script_lexer_core: done, clean");
        end else begin
            $display("tb_script_lexer_core: done, errors");
        end
        $finish;
    end

endmodule
